>>> design/bdpm_pkg.sv
`default_nettype none

package bdpm_pkg;

	localparam int MAX_BOXES_DEF = 16;

	localparam int SLOT_W   = 4;
	localparam int CORNER_W = 16;
	localparam int POS_W    = 12;
	localparam int ROI_W    = 12;
	localparam int SIZE_W   = 13;
	localparam int COUNT_W  = 5;
	localparam int WORD_W   = 32;
	localparam int NUM_CH   = 3;

	// image-space coordinate after clamping: roi_x + roi_width - 1 needs 14 bits
	localparam int COORD_W  = 14;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [SIZE_W-1:0] ROI_SIZE_RESET = 13'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROI_X      = 3'd0,
		CFG_ROI_Y      = 3'd1,
		CFG_ROI_WIDTH  = 3'd2,
		CFG_ROI_HEIGHT = 3'd3,
		CFG_NUM_BOXES  = 3'd4,
		CFG_THREE_CH   = 3'd5,
		CFG_DROP_WORD  = 3'd6
	} cfg_idx_t;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic signed [CORNER_W-1:0] left;
		logic signed [CORNER_W-1:0] top;
		logic signed [CORNER_W-1:0] right;
		logic signed [CORNER_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		coord_t rx;
		coord_t xmax;
		coord_t ry;
		coord_t ymax;
	} roi_lim_t;

	typedef struct packed {
		coord_t px;
		coord_t py;
	} pix_pos_t;

	typedef logic [NUM_CH-1:0][WORD_W-1:0] chan_t;

	// clamp a signed corner into [lo, hi], lo <= hi
	function automatic coord_t clamp_coord(logic signed [CORNER_W-1:0] v, coord_t lo,
		coord_t hi);
		logic signed [CORNER_W:0] vs;
		logic signed [CORNER_W:0] ls;
		logic signed [CORNER_W:0] hs;
		coord_t res;
		vs = (CORNER_W+1)'(v);
		ls = $signed({{(CORNER_W+1-COORD_W){1'b0}}, lo});
		hs = $signed({{(CORNER_W+1-COORD_W){1'b0}}, hi});
		if (vs < ls) begin
			res = lo;
		end else if (vs > hs) begin
			res = hi;
		end else begin
			res = v[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> design/bdpm_if.sv
`default_nettype none

interface bdpm_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  cmd;
	logic [bdpm_pkg::SLOT_W-1:0]           box_slot;
	logic signed [bdpm_pkg::CORNER_W-1:0]  box_left;
	logic signed [bdpm_pkg::CORNER_W-1:0]  box_top;
	logic signed [bdpm_pkg::CORNER_W-1:0]  box_right;
	logic signed [bdpm_pkg::CORNER_W-1:0]  box_bottom;
	logic [bdpm_pkg::POS_W-1:0]            pixel_col;
	logic [bdpm_pkg::POS_W-1:0]            pixel_row;
	logic [bdpm_pkg::WORD_W-1:0]           in_chan0;
	logic [bdpm_pkg::WORD_W-1:0]           in_chan1;
	logic [bdpm_pkg::WORD_W-1:0]           in_chan2;

	modport source(output valid, cmd, box_slot, box_left, box_top, box_right, box_bottom,
		pixel_col, pixel_row, in_chan0, in_chan1, in_chan2, input ready);
	modport sink(input valid, cmd, box_slot, box_left, box_top, box_right, box_bottom,
		pixel_col, pixel_row, in_chan0, in_chan1, in_chan2, output ready);
endinterface

interface bdpm_out_if;
	logic                        valid;
	logic                        ready;
	logic [bdpm_pkg::WORD_W-1:0] out_chan0;
	logic [bdpm_pkg::WORD_W-1:0] out_chan1;
	logic [bdpm_pkg::WORD_W-1:0] out_chan2;
	logic                        dropped;

	modport source(output valid, out_chan0, out_chan1, out_chan2, dropped, input ready);
	modport sink(input valid, out_chan0, out_chan1, out_chan2, dropped, output ready);
endinterface

interface bdpm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bdpm_pkg::CFG_IDX_W-1:0]  index;
	logic [bdpm_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/bdpm_lane.sv
`default_nettype none

module bdpm_lane (
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire logic               wr,
	input  wire bdpm_pkg::box_t     box_in,
	input  wire bdpm_pkg::roi_lim_t lim,
	input  wire logic               active,
	input  wire bdpm_pkg::pix_pos_t pos_s1,
	input  wire bdpm_pkg::pix_pos_t pos_s2,
	output logic                    hit_s3
);

	bdpm_pkg::box_t   ent_q;
	bdpm_pkg::coord_t x1_s1;
	bdpm_pkg::coord_t y1_s1;
	bdpm_pkg::coord_t xmax_s1;
	bdpm_pkg::coord_t ymax_s1;
	logic signed [bdpm_pkg::CORNER_W-1:0] right_s1;
	logic signed [bdpm_pkg::CORNER_W-1:0] bottom_s1;
	bdpm_pkg::coord_t x2_s2;
	bdpm_pkg::coord_t y2_s2;
	logic             lo_s2;

	// table entry and clamped corners all move on the pipeline advance, so
	// a pixel sees exactly the loads accepted ahead of it
	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q <= box_in;
		end
		if (adv) begin
			x1_s1     <= bdpm_pkg::clamp_coord(ent_q.left, lim.rx, lim.xmax);
			y1_s1     <= bdpm_pkg::clamp_coord(ent_q.top, lim.ry, lim.ymax);
			xmax_s1   <= lim.xmax;
			ymax_s1   <= lim.ymax;
			right_s1  <= ent_q.right;
			bottom_s1 <= ent_q.bottom;
			x2_s2     <= bdpm_pkg::clamp_coord(right_s1, x1_s1, xmax_s1);
			y2_s2     <= bdpm_pkg::clamp_coord(bottom_s1, y1_s1, ymax_s1);
			lo_s2     <= (pos_s1.px >= x1_s1) && (pos_s1.py >= y1_s1);
			hit_s3    <= active && lo_s2 && (pos_s2.px <= x2_s2) && (pos_s2.py <= y2_s2);
		end
	end

endmodule

`default_nettype wire

>>> design/box_dropout_pixel_mask.sv
`default_nettype none

// channel   modport  item
// pix_in    sink     load box (cmd 0) or pixel (cmd 1) with up to three channels
// pix_out   source   one result per pixel item: channels and dropped flag
// cfg       sink     register write: index, data
//
// one item per cycle unless the output stalls, registered through s1 to s4; the box compare
// lanes run in parallel, one per table slot, so the box count does not cost cycles.
// a full output stalls the whole pipeline; pix_in.ready follows it.
// reset clears the registers and pipeline valids, not the box table.
// cfg is always ready.

module box_dropout_pixel_mask #(
	parameter int MAX_BOXES = bdpm_pkg::MAX_BOXES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bdpm_in_if.sink   pix_in,
	bdpm_out_if.source pix_out,
	bdpm_cfg_if.sink  cfg
);

	// wide enough for num_boxes and every lane index
	localparam int CmpW = $clog2(MAX_BOXES + 32);

	logic [bdpm_pkg::ROI_W-1:0]   roi_x_q;
	logic [bdpm_pkg::ROI_W-1:0]   roi_y_q;
	logic [bdpm_pkg::SIZE_W-1:0]  roi_width_q;
	logic [bdpm_pkg::SIZE_W-1:0]  roi_height_q;
	logic [bdpm_pkg::COUNT_W-1:0] num_boxes_q;
	logic                         three_ch_q;
	logic [bdpm_pkg::WORD_W-1:0]  drop_word_q;

	logic adv;
	logic acc;

	assign adv          = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = adv;
	assign acc          = pix_in.valid && adv;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_x_q      <= '0;
			roi_y_q      <= '0;
			roi_width_q  <= bdpm_pkg::ROI_SIZE_RESET;
			roi_height_q <= bdpm_pkg::ROI_SIZE_RESET;
			num_boxes_q  <= '0;
			three_ch_q   <= 1'b1;
			drop_word_q  <= '0;
		end else if (cfg.valid) begin
			unique case (bdpm_pkg::cfg_idx_t'(cfg.index))
				bdpm_pkg::CFG_ROI_X:      roi_x_q      <= cfg.data[bdpm_pkg::ROI_W-1:0];
				bdpm_pkg::CFG_ROI_Y:      roi_y_q      <= cfg.data[bdpm_pkg::ROI_W-1:0];
				bdpm_pkg::CFG_ROI_WIDTH:  roi_width_q  <= cfg.data[bdpm_pkg::SIZE_W-1:0];
				bdpm_pkg::CFG_ROI_HEIGHT: roi_height_q <= cfg.data[bdpm_pkg::SIZE_W-1:0];
				bdpm_pkg::CFG_NUM_BOXES:  num_boxes_q  <= cfg.data[bdpm_pkg::COUNT_W-1:0];
				bdpm_pkg::CFG_THREE_CH:   three_ch_q   <= cfg.data[0];
				bdpm_pkg::CFG_DROP_WORD:  drop_word_q  <= cfg.data[bdpm_pkg::WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// roi limits in image space; a zero size counts as one
	bdpm_pkg::roi_lim_t lim;
	logic [bdpm_pkg::SIZE_W-1:0] wz;
	logic [bdpm_pkg::SIZE_W-1:0] hz;

	always_comb begin
		wz = (roi_width_q == '0) ? bdpm_pkg::SIZE_W'(1) : roi_width_q;
		hz = (roi_height_q == '0) ? bdpm_pkg::SIZE_W'(1) : roi_height_q;
		lim.rx   = bdpm_pkg::COORD_W'(roi_x_q);
		lim.ry   = bdpm_pkg::COORD_W'(roi_y_q);
		lim.xmax = bdpm_pkg::COORD_W'(roi_x_q) + bdpm_pkg::COORD_W'(wz)
			- bdpm_pkg::COORD_W'(1);
		lim.ymax = bdpm_pkg::COORD_W'(roi_y_q) + bdpm_pkg::COORD_W'(hz)
			- bdpm_pkg::COORD_W'(1);
	end

	bdpm_pkg::box_t box_in;
	assign box_in = '{left: pix_in.box_left, top: pix_in.box_top,
		right: pix_in.box_right, bottom: pix_in.box_bottom};

	// pixel pipeline
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	bdpm_pkg::pix_pos_t pos_s1, pos_s2;
	bdpm_pkg::chan_t    ch_s1, ch_s2, ch_s3;
	logic [MAX_BOXES-1:0] hit_s3;

	bdpm_pkg::chan_t out_s4;
	logic            drop_s4;
	logic            hit_any;

	assign hit_any = |hit_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			// load items leave no result, only pixels travel as valid
			vld_s1 <= acc && pix_in.cmd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// image-space pixel position, so outside-roi pixels fall past xmax
			pos_s1.px <= bdpm_pkg::COORD_W'(pix_in.pixel_col) + bdpm_pkg::COORD_W'(roi_x_q);
			pos_s1.py <= bdpm_pkg::COORD_W'(pix_in.pixel_row) + bdpm_pkg::COORD_W'(roi_y_q);
			ch_s1     <= {pix_in.in_chan2, pix_in.in_chan1, pix_in.in_chan0};
			pos_s2    <= pos_s1;
			ch_s2     <= ch_s1;
			ch_s3     <= ch_s2;
			out_s4[0] <= hit_any ? drop_word_q : ch_s3[0];
			out_s4[1] <= !three_ch_q ? '0 : (hit_any ? drop_word_q : ch_s3[1]);
			out_s4[2] <= !three_ch_q ? '0 : (hit_any ? drop_word_q : ch_s3[2]);
			drop_s4   <= hit_any;
		end
	end

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_lane
		logic wr;
		logic active;

		assign wr     = acc && !pix_in.cmd && (CmpW'(pix_in.box_slot) == CmpW'(i));
		assign active = CmpW'(num_boxes_q) > CmpW'(i);

		bdpm_lane u_lane (
			.clk    (clk),
			.adv    (adv),
			.wr     (wr),
			.box_in (box_in),
			.lim    (lim),
			.active (active),
			.pos_s1 (pos_s1),
			.pos_s2 (pos_s2),
			.hit_s3 (hit_s3[i])
		);
	end

	assign pix_out.valid     = vld_s4;
	assign pix_out.out_chan0 = out_s4[0];
	assign pix_out.out_chan1 = out_s4[1];
	assign pix_out.out_chan2 = out_s4[2];
	assign pix_out.dropped   = drop_s4;

endmodule

`default_nettype wire
